### hw/rtl/tstf_pkg.sv
// Shared types and constants for the touch sample triple filter.
package tstf_pkg;

	// Fixed field widths
	localparam int FIELD_W   = 12;
	localparam int POS_W     = 12;
	localparam int THRESH_W  = 12;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// Touch framing: nine samples as three groups of three
	localparam int GROUP_COUNT   = 3;
	localparam int GROUP_SIZE    = 3;
	localparam int TOUCH_SAMPLES = GROUP_COUNT * GROUP_SIZE;

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(2);

	// Register index carried in paddr[2]
	localparam logic REG_THRESH = 1'b0;

	typedef logic [3:0] count_t;
	typedef logic [1:0] grp_t;

	localparam grp_t GRP_FIRST  = 2'd0;
	localparam grp_t GRP_SECOND = 2'd1;
	localparam grp_t GRP_THIRD  = 2'd2;

	typedef enum logic [1:0] {
		ST_VALID      = 2'd0,
		ST_LIFTED     = 2'd1,
		ST_X_UNSTABLE = 2'd2,
		ST_Y_UNSTABLE = 2'd3
	} status_t;

	// Control sent from the sequencer to each axis lane
	typedef struct packed {
		logic acc_en;   // item accepted, add sample
		logic clear;    // item ends the touch, zero the sums
		grp_t grp;      // group the sample belongs to
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ctrl_t;

endpackage

### hw/rtl/tstf_axis_lane.sv
// One axis lane: group accumulation, means, differences, pair choice.
module tstf_axis_lane
	import tstf_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pipe_ctrl_t             ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [THRESH_W-1:0]    threshold,
	output logic                   ok_s4,
	output logic [POS_W-1:0]       pos_s4
);

	localparam int SUM_W  = SAMPLE_BITS + 2;
	// floor(v/3) = (v * K) >> S, exact for v < 2**(S-1); S even
	localparam int DIV_S  = ((SUM_W + 1) % 2 == 0) ? SUM_W + 1 : SUM_W + 2;
	localparam int DIV_K  = (2**DIV_S + 2) / 3;
	localparam int PROD_W = SUM_W + DIV_S;
	localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	logic [SUM_W-1:0]       sums_q  [GROUP_COUNT];
	logic [SUM_W-1:0]       acc_nxt [GROUP_COUNT];
	logic [SUM_W-1:0]       sums_s1 [GROUP_COUNT];
	logic [PROD_W-1:0]      prod    [GROUP_COUNT];
	logic [SAMPLE_BITS-1:0] mean_s2 [GROUP_COUNT];
	logic [SAMPLE_BITS-1:0] mean_s3 [GROUP_COUNT];
	logic [SAMPLE_BITS-1:0] d01_s3, d12_s3, d20_s3;
	logic [SAMPLE_BITS-1:0] pick_a, pick_b;
	logic [SAMPLE_BITS:0]   pair_sum;
	logic [CMP_W-1:0]       thr_ext;
	logic                   unstable;

	// Sum including the current sample for its group
	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			acc_nxt[g] = (ctrl.grp == grp_t'(g)) ? sums_q[g] + SUM_W'(sample) : sums_q[g];
		end
	end

	// Running group sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUP_COUNT; g++) sums_q[g] <= '0;
		end else if (ctrl.acc_en) begin
			for (int g = 0; g < GROUP_COUNT; g++) sums_q[g] <= ctrl.clear ? '0 : acc_nxt[g];
		end
	end

	// Stage 1: final sums of the touch
	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			for (int g = 0; g < GROUP_COUNT; g++) sums_s1[g] <= acc_nxt[g];
		end
	end

	// Divide by three through the reciprocal
	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			prod[g] = PROD_W'(sums_s1[g]) * PROD_W'(DIV_K);
		end
	end

	// Stage 2: group means
	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			for (int g = 0; g < GROUP_COUNT; g++) mean_s2[g] <= prod[g][DIV_S +: SAMPLE_BITS];
		end
	end

	// Stage 3: absolute differences
	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			for (int g = 0; g < GROUP_COUNT; g++) mean_s3[g] <= mean_s2[g];
			d01_s3 <= (mean_s2[0] > mean_s2[1]) ? mean_s2[0] - mean_s2[1] : mean_s2[1] - mean_s2[0];
			d12_s3 <= (mean_s2[1] > mean_s2[2]) ? mean_s2[1] - mean_s2[2] : mean_s2[2] - mean_s2[1];
			d20_s3 <= (mean_s2[2] > mean_s2[0]) ? mean_s2[2] - mean_s2[0] : mean_s2[0] - mean_s2[2];
		end
	end

	// Stability check and closest-pair choice
	always_comb begin
		thr_ext  = CMP_W'(threshold);
		unstable = (CMP_W'(d01_s3) > thr_ext) && (CMP_W'(d12_s3) > thr_ext)
			&& (CMP_W'(d20_s3) > thr_ext);
		priority if (d01_s3 < d12_s3) begin
			if (d20_s3 < d01_s3) begin
				pick_a = mean_s3[0];
				pick_b = mean_s3[2];
			end else begin
				pick_a = mean_s3[0];
				pick_b = mean_s3[1];
			end
		end else if (d20_s3 < d12_s3) begin
			pick_a = mean_s3[0];
			pick_b = mean_s3[2];
		end else begin
			pick_a = mean_s3[1];
			pick_b = mean_s3[2];
		end
		pair_sum = {1'b0, pick_a} + {1'b0, pick_b};
	end

	// Stage 4: lane verdict and position
	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			ok_s4  <= !unstable;
			pos_s4 <= POS_W'(pair_sum[SAMPLE_BITS:1]);
		end
	end

endmodule

### hw/rtl/touch_sample_triple_filter_top.sv
// Top level: sample sequencing, X and Y lanes, result merge, output register.
//
//  channel | dir | handshake              | payload
//  s_*     | in  | s_tvalid / s_tready    | tdata x_sample, y_sample; tuser pen_down
//  m_*     | out | m_tvalid / m_tready    | tdata x_pos, y_pos; tuser status
//  apb     | in  | psel & penable, pready | stability_threshold at 0x0
//
// One sample item is taken per cycle while s_tready is high. The item that
// ends a touch (ninth sample or early pen lift) has its sums captured at
// the edge that accepts it, then passes through divide, differences, pair
// choice and the merge into the output register before it shows on m_tvalid.
// Reset clears counter, sums and all stage valids at once and sets the
// threshold to 2. A stalled output backs up the stages one by one; the input
// stalls only when the first stage is held.
module touch_sample_triple_filter_top
	import tstf_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // [11:0] x_sample, [23:12] y_sample
	input  logic [0:0]            s_tuser,   // [0] pen_down
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [11:0] x_pos, [23:12] y_pos
	output logic [1:0]            m_tuser,   // [1:0] status
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [THRESH_W-1:0]    thresh_q;
	count_t                 count_q;
	grp_t                   grp;
	logic                   accept, ninth, terminate;
	logic [SAMPLE_BITS-1:0] xs, ys;
	pipe_ctrl_t             ctrl;
	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic                   lifted_s1, lifted_s2, lifted_s3, lifted_s4;
	logic                   out_free, free_s4, free_s3, free_s2;
	logic                   ld_out;
	logic                   x_ok_s4, y_ok_s4;
	logic [POS_W-1:0]       x_pos_s4, y_pos_s4;
	status_t                status;
	logic                   m_tvalid_q;
	logic [23:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESH) ? CFG_DATA_W'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESH) begin
			thresh_q <= pwdata[THRESH_W-1:0];
		end
	end

	// Stall chain, output back to input
	assign out_free = !m_tvalid_q || m_tready;
	assign ld_out   = valid_s4 && out_free;
	assign free_s4  = !valid_s4 || out_free;
	assign free_s3  = !valid_s3 || free_s4;
	assign free_s2  = !valid_s2 || free_s3;
	assign s_tready = !valid_s1 || free_s2;

	// Sample sequencing
	assign accept    = s_tvalid && s_tready;
	assign ninth     = (count_q == count_t'(TOUCH_SAMPLES - 1));
	assign terminate = ninth || !s_tuser[0];
	assign xs        = SAMPLE_BITS'(s_tdata[FIELD_W-1:0]);
	assign ys        = SAMPLE_BITS'(s_tdata[2*FIELD_W-1:FIELD_W]);

	always_comb begin
		priority if (count_q < count_t'(GROUP_SIZE)) grp = GRP_FIRST;
		else if (count_q < count_t'(2 * GROUP_SIZE)) grp = GRP_SECOND;
		else grp = GRP_THIRD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= terminate ? '0 : count_q + count_t'(1);
		end
	end

	assign ctrl.acc_en = accept;
	assign ctrl.clear  = terminate;
	assign ctrl.grp    = grp;
	assign ctrl.ld_s1  = accept && terminate;
	assign ctrl.ld_s2  = valid_s1 && free_s2;
	assign ctrl.ld_s3  = valid_s2 && free_s3;
	assign ctrl.ld_s4  = valid_s3 && free_s4;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.ld_s1 || (valid_s1 && !free_s2);
			valid_s2 <= ctrl.ld_s2 || (valid_s2 && !free_s3);
			valid_s3 <= ctrl.ld_s3 || (valid_s3 && !free_s4);
			valid_s4 <= ctrl.ld_s4 || (valid_s4 && !out_free);
		end
	end

	// Early-lift flag rides along with the touch
	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) lifted_s1 <= !ninth;
		if (ctrl.ld_s2) lifted_s2 <= lifted_s1;
		if (ctrl.ld_s3) lifted_s3 <= lifted_s2;
		if (ctrl.ld_s4) lifted_s4 <= lifted_s3;
	end

	// Axis lanes
	tstf_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample    (xs),
		.threshold (thresh_q),
		.ok_s4     (x_ok_s4),
		.pos_s4    (x_pos_s4)
	);

	tstf_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample    (ys),
		.threshold (thresh_q),
		.ok_s4     (y_ok_s4),
		.pos_s4    (y_pos_s4)
	);

	// Merge lane verdicts; early lift wins, then X is checked before Y
	always_comb begin
		priority if (lifted_s4) status = ST_LIFTED;
		else if (!x_ok_s4) status = ST_X_UNSTABLE;
		else if (!y_ok_s4) status = ST_Y_UNSTABLE;
		else status = ST_VALID;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			m_tuser_q <= status;
			m_tdata_q <= (status == ST_VALID) ? {y_pos_s4, x_pos_s4} : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < count_t'(TOUCH_SAMPLES))
		else $error("sample counter out of range");

	a_touch_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && terminate) |=> (count_q == '0))
		else $error("counter not cleared after touch end");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_VALID) |-> (m_tdata == '0))
		else $error("rejected touch carries a position");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !free_s2) |-> !s_tready)
		else $error("first stage overwritten while held");

endmodule
